// ===== sv/sljx_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sljx_pkg
// Shared types and constants of the sync, length and XOR frame parser.
// ----------------------------------------------------------------------------
package sljx_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CountW  = 9;
  localparam int unsigned StatusW = 2;

  localparam logic [ByteW-1:0]  SyncReset = 8'hAA;
  localparam logic [CountW-1:0] CountMax  = 9'd511;
  localparam logic [CountW:0]   MinFrame  = 10'd4;

  // header byte positions
  localparam logic [CountW-1:0] PosSync = 9'd0;
  localparam logic [CountW-1:0] PosCid  = 9'd1;
  localparam logic [CountW-1:0] PosLen  = 9'd2;
  localparam logic [CountW-1:0] PosData = 9'd3;

  localparam logic KindPayload = 1'b0;
  localparam logic KindStatus  = 1'b1;

  localparam logic [StatusW-1:0] StatusOk     = 2'd0;
  localparam logic [StatusW-1:0] StatusLenErr = 2'd1;
  localparam logic [StatusW-1:0] StatusDatErr = 2'd2;

  typedef struct packed {
    logic               kind;
    logic [ByteW-1:0]   payload_byte;
    logic [ByteW-1:0]   payload_index;
    logic [ByteW-1:0]   command_id;
    logic [ByteW-1:0]   payload_length;
    logic [StatusW-1:0] status;
  } result_t;

endpackage
`default_nettype wire

// ===== sv/sljx_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sljx_if
// Valid/ready channels of the frame parser: byte input and result output.
// ----------------------------------------------------------------------------
interface sljx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_frame;

  modport source (output valid, output data_byte, output end_of_frame, input ready);
  modport sink   (input valid, input data_byte, input end_of_frame, output ready);
endinterface

interface sljx_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] payload_byte;
  logic [7:0] payload_index;
  logic [7:0] command_id;
  logic [7:0] payload_length;
  logic [1:0] status;

  modport source (output valid, output kind, output payload_byte, output payload_index,
                  output command_id, output payload_length, output status, input ready);
  modport sink   (input valid, input kind, input payload_byte, input payload_index,
                  input command_id, input payload_length, input status, output ready);
endinterface
`default_nettype wire

// ===== sv/sljx_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sljx_parser
// Frame state (count, XOR, header bytes) and the per-byte result decode.
// ----------------------------------------------------------------------------
module sljx_parser (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      fire_i,
  input  wire logic [sljx_pkg::ByteW-1:0] data_byte_i,
  input  wire logic                      end_of_frame_i,
  input  wire logic [sljx_pkg::ByteW-1:0] sync_byte_i,
  output logic                           res_valid_o,
  output sljx_pkg::result_t              res_o
);

  logic [sljx_pkg::CountW-1:0] count_q, count_d;
  logic [sljx_pkg::ByteW-1:0]  xor_q, xor_d;
  logic                        sync_q, sync_d;
  logic [sljx_pkg::ByteW-1:0]  cid_q, cid_d;
  logic [sljx_pkg::ByteW-1:0]  len_q, len_d;

  logic [sljx_pkg::CountW-1:0] rel_pos;
  logic [sljx_pkg::CountW:0]   frame_size;
  logic [sljx_pkg::CountW:0]   want_size;
  logic                        in_payload;

  assign rel_pos    = count_q - sljx_pkg::PosData;
  assign frame_size = {1'b0, count_q} + 10'd1;
  assign want_size  = sljx_pkg::MinFrame + {2'b00, len_q};
  assign in_payload = sync_q && (count_q >= sljx_pkg::PosData)
                      && (rel_pos < {1'b0, len_q});

  always_comb begin
    count_d     = count_q;
    xor_d       = xor_q;
    sync_d      = sync_q;
    cid_d       = cid_q;
    len_d       = len_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (fire_i) begin
      if (!end_of_frame_i) begin
        if (count_q == sljx_pkg::PosSync) begin
          sync_d = (data_byte_i == sync_byte_i);
        end else begin
          xor_d = xor_q ^ data_byte_i;
        end
        if (count_q == sljx_pkg::PosCid) begin
          cid_d = data_byte_i;
        end
        if (count_q == sljx_pkg::PosLen) begin
          len_d = data_byte_i;
        end
        if (count_q < sljx_pkg::CountMax) begin
          count_d = count_q + 9'd1;
        end
        // header bytes never satisfy in_payload, so stored values are current
        res_valid_o          = in_payload;
        res_o.kind           = sljx_pkg::KindPayload;
        res_o.payload_byte   = data_byte_i;
        res_o.payload_index  = rel_pos[sljx_pkg::ByteW-1:0];
        res_o.command_id     = cid_q;
        res_o.payload_length = len_q;
        res_o.status         = sljx_pkg::StatusOk;
      end else begin
        res_valid_o          = 1'b1;
        res_o.kind           = sljx_pkg::KindStatus;
        res_o.command_id     = (count_q == sljx_pkg::PosCid) ? data_byte_i : cid_q;
        res_o.payload_length = (count_q == sljx_pkg::PosLen) ? data_byte_i : len_q;
        if (frame_size < sljx_pkg::MinFrame) begin
          res_o.status = sljx_pkg::StatusLenErr;
        end else if (!sync_q) begin
          res_o.status = sljx_pkg::StatusDatErr;
        end else if (frame_size != want_size) begin
          res_o.status = sljx_pkg::StatusLenErr;
        end else if (xor_q != data_byte_i) begin
          res_o.status = sljx_pkg::StatusDatErr;
        end else begin
          res_o.status = sljx_pkg::StatusOk;
        end
        count_d = '0;
        xor_d   = '0;
        sync_d  = 1'b0;
        cid_d   = '0;
        len_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      xor_q   <= '0;
      sync_q  <= 1'b0;
      cid_q   <= '0;
      len_q   <= '0;
    end else begin
      count_q <= count_d;
      xor_q   <= xor_d;
      sync_q  <= sync_d;
      cid_q   <= cid_d;
      len_q   <= len_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/sljx_out_skid.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sljx_out_skid
// Result register with a skid entry so the input side never waits on a
// combinational ready from the receiver.
// ----------------------------------------------------------------------------
module sljx_out_skid (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  sljx_pkg::result_t      push_data_i,
  output logic                   space_o,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output sljx_pkg::result_t      data_o
);

  logic              main_vld_q, main_vld_d;
  logic              skid_vld_q, skid_vld_d;
  sljx_pkg::result_t main_q, main_d;
  sljx_pkg::result_t skid_q, skid_d;

  assign space_o = !skid_vld_q;
  assign valid_o = main_vld_q;
  assign data_o  = main_q;

  always_comb begin
    main_vld_d = main_vld_q;
    skid_vld_d = skid_vld_q;
    main_d     = main_q;
    skid_d     = skid_q;
    if (ready_i || !main_vld_q) begin
      main_vld_d = skid_vld_q || push_i;
      main_d     = skid_vld_q ? skid_q : push_data_i;
      skid_vld_d = 1'b0;
    end else if (push_i) begin
      // main entry stalled: park the new request
      skid_vld_d = 1'b1;
      skid_d     = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      main_vld_q <= main_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule
`default_nettype wire

// ===== sv/sync_length_xor_frame_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sync_length_xor_frame_parser
// Byte-wise parser for sync / id / length / payload / XOR-checksum frames.
// ----------------------------------------------------------------------------
// Usage:
//   in_i takes one frame byte per request, end_of_frame set on the last one.
//   out_o gives zero or one result per input request: a payload byte
//   (kind 0) for each byte inside the declared payload of a frame whose sync
//   byte matched, and one status (kind 1) on the last byte of every frame.
//   cfg_we_i / cfg_wdata_i write the expected sync byte (0xAA after reset);
//   the value is sampled when byte 0 of a frame arrives.
// Timing:
//   One byte per cycle while the output buffer has room. Results are registered
//   in the main entry, or in the skid entry while the main one is stalled; the
//   decode sits between frame state and result register. Two entries keep in_i
//   ready while one result waits; in_i drops ready only when both are full.
// Reset:
//   Frame state and output buffer are cleared, sync byte returns to 0xAA.
// ----------------------------------------------------------------------------
module sync_length_xor_frame_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  sljx_in_if.sink          in_i,
  sljx_out_if.source       out_o,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i
);

  logic [sljx_pkg::ByteW-1:0] sync_q;
  logic                       space;
  logic                       fire;
  logic                       res_valid;
  sljx_pkg::result_t          res;
  sljx_pkg::result_t          out_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= sljx_pkg::SyncReset;
    end else if (cfg_we_i) begin
      sync_q <= cfg_wdata_i;
    end
  end

  assign in_i.ready = space;
  assign fire       = in_i.valid && space;

  sljx_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .data_byte_i    (in_i.data_byte),
    .end_of_frame_i (in_i.end_of_frame),
    .sync_byte_i    (sync_q),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  sljx_out_skid u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .space_o     (space),
    .valid_o     (out_o.valid),
    .ready_i     (out_o.ready),
    .data_o      (out_data)
  );

  assign out_o.kind           = out_data.kind;
  assign out_o.payload_byte   = out_data.payload_byte;
  assign out_o.payload_index  = out_data.payload_index;
  assign out_o.command_id     = out_data.command_id;
  assign out_o.payload_length = out_data.payload_length;
  assign out_o.status         = out_data.status;

endmodule
`default_nettype wire

// ===== sim/sync_length_xor_frame_parser_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sync_length_xor_frame_parser_tb
// Self-checking bench for the frame parser. A scoreboard tracks the frame
// state, predicts the payload and status results of every accepted byte and
// checks them in order. The stimulus is a short directed set of frame shapes,
// then random frames under four sync values, with random stalls on both
// channels and one long output hold-off.
// ----------------------------------------------------------------------------
module sync_length_xor_frame_parser_tb;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned LongHold   = 400;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned DrainWait  = 4;

  typedef logic [7:0] byteq_t[$];

  class frame_scoreboard;
    logic [sljx_pkg::ByteW-1:0]  sync_value;
    logic [sljx_pkg::CountW-1:0] byte_count;
    logic [sljx_pkg::ByteW-1:0]  run_xor;
    logic [sljx_pkg::ByteW-1:0]  cid;
    logic [sljx_pkg::ByteW-1:0]  plen;
    logic                        sync_ok;
    sljx_pkg::result_t           expected_q[$];
    int unsigned                 bytes_in;
    int unsigned                 n_payload;
    int unsigned                 n_status;
    int unsigned                 mismatches;
    int unsigned                 status_seen[3];

    function new();
      sync_value = sljx_pkg::SyncReset;
      bytes_in   = 0;
      n_payload  = 0;
      n_status   = 0;
      mismatches = 0;
      status_seen = '{0, 0, 0};
      clear_frame();
    endfunction

    function void clear_frame();
      byte_count = '0;
      run_xor    = '0;
      sync_ok    = 1'b0;
      cid        = '0;
      plen       = '0;
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction

    // predict the result, if any, of one accepted request
    function void note_byte(logic [7:0] b, logic eof);
      logic [sljx_pkg::CountW-1:0] pos;
      logic [sljx_pkg::CountW:0]   size;
      sljx_pkg::result_t           r;
      pos = byte_count;
      r   = '0;
      bytes_in++;
      if (!eof) begin
        if (pos == sljx_pkg::PosSync) sync_ok = (b == sync_value);
        else run_xor = run_xor ^ b;
        if (pos == sljx_pkg::PosCid) cid = b;
        if (pos == sljx_pkg::PosLen) plen = b;
        if (byte_count < sljx_pkg::CountMax) byte_count = byte_count + 1'b1;
        if (sync_ok && pos >= sljx_pkg::PosData &&
            (pos - sljx_pkg::PosData) < {1'b0, plen}) begin
          r.kind           = sljx_pkg::KindPayload;
          r.payload_byte   = b;
          r.payload_index  = 8'(pos - sljx_pkg::PosData);
          r.command_id     = cid;
          r.payload_length = plen;
          r.status         = sljx_pkg::StatusOk;
          expected_q.push_back(r);
        end
      end else begin
        size = {1'b0, pos} + 1'b1;
        r.kind           = sljx_pkg::KindStatus;
        r.command_id     = (pos == sljx_pkg::PosCid) ? b : cid;
        r.payload_length = (pos == sljx_pkg::PosLen) ? b : plen;
        if (size < sljx_pkg::MinFrame) r.status = sljx_pkg::StatusLenErr;
        else if (!sync_ok) r.status = sljx_pkg::StatusDatErr;
        else if (size != sljx_pkg::MinFrame + plen) r.status = sljx_pkg::StatusLenErr;
        else if (run_xor != b) r.status = sljx_pkg::StatusDatErr;
        else r.status = sljx_pkg::StatusOk;
        expected_q.push_back(r);
        clear_frame();
      end
    endfunction

    function string describe(sljx_pkg::result_t r);
      return $sformatf("kind %0d byte %02h idx %0d cid %02h len %0d status %0d",
                       r.kind, r.payload_byte, r.payload_index, r.command_id,
                       r.payload_length, r.status);
    endfunction

    function void check_result(sljx_pkg::result_t got);
      sljx_pkg::result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("[%0t] unexpected result: %s", $time, describe(got));
        return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
          got.payload_index !== want.payload_index ||
          got.command_id !== want.command_id ||
          got.payload_length !== want.payload_length || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("[%0t] mismatch: expected %s, actual %s", $time, describe(want),
                   describe(got));
      end else if (got.kind == sljx_pkg::KindStatus) begin
        n_status++;
        status_seen[got.status]++;
      end else begin
        n_payload++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;
  logic        idle_en;
  logic        long_hold_req;
  int unsigned cycle_count = 0;

  sljx_in_if  in_ch ();
  sljx_out_if out_ch ();

  frame_scoreboard sb;

  sync_length_xor_frame_parser uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CycleLimit);
    $display("[%0t] run stopped at the cycle limit", $time);
    $display("end of test: mismatches");
    $finish;
  end

  // result side: random stall bursts, one long hold-off on request
  initial begin : sink_side
    int unsigned gap;
    int unsigned held;
    logic        hold_done;
    gap       = 0;
    held      = 0;
    hold_done = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (long_hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        held++;
        if (held >= LongHold) hold_done = 1'b1;
      end else if (gap != 0) begin
        out_ch.ready <= 1'b0;
        gap--;
      end else begin
        out_ch.ready <= 1'b1;
        if (idle_en && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 19);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(sljx_pkg::result_t'{out_ch.kind, out_ch.payload_byte,
                                          out_ch.payload_index, out_ch.command_id,
                                          out_ch.payload_length, out_ch.status});
  end

  function automatic byteq_t build_frame(logic [7:0] sync, logic [7:0] id, byteq_t body);
    byteq_t     f;
    logic [7:0] cs;
    cs = id ^ 8'(body.size());
    f  = '{sync, id, 8'(body.size())};
    foreach (body[i]) begin
      f.push_back(body[i]);
      cs = cs ^ body[i];
    end
    f.push_back(cs);
    return f;
  endfunction

  // entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic eof);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.data_byte    <= b;
    in_ch.end_of_frame <= eof;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_byte(b, eof);
    @(negedge clk);
  endtask

  task automatic send_bytes(input byteq_t f);
    foreach (f[i]) send_byte(f[i], i == f.size() - 1);
  endtask

  task automatic write_sync(input logic [7:0] v);
    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    // a byte with no result may still be in flight
    repeat (DrainWait) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.sync_value = v;
  endtask

  task automatic send_random_frame();
    byteq_t      body;
    byteq_t      f;
    int unsigned n;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    n = ($urandom_range(0, 59) == 0) ? $urandom_range(11, 255) : $urandom_range(0, 10);
    for (int i = 0; i < n; i++) body.push_back(8'($urandom));
    f = build_frame(sb.sync_value, 8'($urandom), body);
    if (pick < 8) begin
      f[0] = f[0] ^ 8'($urandom_range(1, 255));
    end else if (pick < 16) begin
      f[f.size() - 1] = f[f.size() - 1] ^ 8'($urandom_range(1, 255));
    end else if (pick < 26) begin
      repeat ($urandom_range(1, f.size() - 1)) void'(f.pop_back());
    end else if (pick < 33) begin
      repeat ($urandom_range(1, 4)) f.push_back(8'($urandom));
    end else if (pick < 40) begin
      f.delete();
      repeat ($urandom_range(1, 6)) f.push_back(8'($urandom));
    end
    send_bytes(f);
  endtask

  task automatic run_random(input int unsigned budget);
    int unsigned start;
    start = sb.bytes_in;
    while (sb.bytes_in - start < budget) send_random_frame();
  endtask

  initial begin : stimulus
    byteq_t      f;
    byteq_t      body;
    logic [7:0]  rand_sync;
    sb = new();
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = 8'h00;
    idle_en            = 1'b1;
    long_hold_req      = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.data_byte    = 8'h00;
    in_ch.end_of_frame = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed shapes under the reset sync value
    send_bytes('{8'hAA});                                   // lone byte
    send_bytes('{8'hAA, 8'h12, 8'h00});                     // header only
    send_bytes(build_frame(8'hAA, 8'hFF, '{8'hFF, 8'h00}));
    send_bytes(build_frame(8'h55, 8'h21, '{8'h7E}));        // sync mismatch
    f = build_frame(8'hAA, 8'h00, '{8'h3C});
    f[3] = f[3] ^ 8'h80;                                    // payload byte flipped, checksum fails
    send_bytes(f);
    f = build_frame(8'hAA, 8'h40, '{8'h01, 8'h02});
    send_bytes(f[0:3]);                                     // ends on a payload byte
    f = build_frame(8'hAA, 8'h50, '{8'h09});
    f.push_back(8'hFF);                                     // trailing byte
    send_bytes(f);
    // sync value changes after byte 0 was taken
    send_byte(8'hAA, 1'b0);
    write_sync(8'h00);
    send_bytes('{8'h11, 8'h00, 8'h11});

    // input backs up behind a long output hold-off
    long_hold_req = 1'b1;
    run_random(100);

    write_sync(8'hFF);
    body.delete();
    repeat (255) body.push_back(8'($urandom));
    f = build_frame(sb.sync_value, 8'($urandom), body);
    while (f.size() < 530) f.push_back(8'($urandom));     // counter saturates
    send_bytes(f);
    run_random(80);

    rand_sync = 8'($urandom_range(1, 254));
    write_sync(rand_sync);
    run_random(90);

    write_sync(sljx_pkg::SyncReset);
    idle_en = 1'b0;
    run_random(110);

    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("%0d bytes sent under sync 0xaa, 0x00, 0xff and 0x%02h; %0d payload bytes",
             sb.bytes_in, rand_sync, sb.n_payload);
    $display("%0d frame statuses: %0d valid, %0d length error, %0d data error",
             sb.n_status, sb.status_seen[sljx_pkg::StatusOk],
             sb.status_seen[sljx_pkg::StatusLenErr],
             sb.status_seen[sljx_pkg::StatusDatErr]);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results still expected", sb.mismatches,
               sb.outstanding());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
